### rtl/core/assert_macros.svh
// Assertion macros shared by the RMS/peak meter RTL.
// Each macro checks on the rising edge of clk and is disabled during rst_n low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked every cycle out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rpf_pkg.sv
// Package for the block RMS and peak finder: payload types, control struct, widths.
// No dependencies.
`timescale 1ns / 1ps

package rpf_pkg;

  localparam int SUM_W  = 64;  // sum of squares
  localparam int CNT_W  = 18;  // sample count
  localparam int POS_W  = 17;  // buffer position
  localparam int THR_W  = 23;  // threshold / rms level
  localparam int ROOT_W = 32;  // full root of a 64-bit value
  localparam int SREM_W = ROOT_W + 1;  // root remainder
  localparam int CSU_W  = SREM_W + 2;  // shared compare/subtract width

  localparam logic [THR_W-1:0] RMS_MAX   = 23'h7FFFFF;
  localparam logic [THR_W-1:0] THR_RESET = 23'h7FFFFF;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [POS_W-1:0]   position;
    logic               last;
  } rpf_in_t;

  typedef struct packed {
    logic [THR_W-1:0] rms_level;
    logic             peak_found;
    logic [POS_W-1:0] peak_position;
    logic [CNT_W-1:0] sample_count;
  } rpf_out_t;

  // Sequencer strobes into the accumulator
  typedef struct packed {
    logic load;   // capture magnitude, check threshold
    logic mul;    // square the magnitude
    logic acc;    // add square, bump count
    logic clear;  // block finished
  } rpf_acc_ctl_t;

endpackage

### rtl/core/rpf_acc.sv
// Per-sample datapath: magnitude, threshold crossing, square and accumulate.
// Depends on rpf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpf_acc #(
  parameter int MAX_FRAMES   = 16384,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rpf_pkg::rpf_acc_ctl_t       ctl,
  input  rpf_pkg::rpf_in_t            in_data,
  input  logic [rpf_pkg::THR_W-1:0]   threshold,
  output logic [rpf_pkg::SUM_W-1:0]   sum,
  output logic [rpf_pkg::CNT_W-1:0]   count,
  output logic                        seen,
  output logic [rpf_pkg::POS_W-1:0]   index
);
  import rpf_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam int CMP_W = THR_W + 2;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_FRAMES * MAX_CHANNELS);

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   over;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   seen_r;
  logic [POS_W-1:0]       idx_r;

  // Magnitude of the sign-extended low sample bits; most negative maps to 2^(N-1)
  always_comb begin
    raw  = in_data.sample[SAMPLE_BITS-1:0];
    mag  = raw[SAMPLE_BITS-1] ? ((~raw) + SAMPLE_BITS'(1)) : raw;
    over = CMP_W'(mag) > CMP_W'(threshold);
  end

  // Magnitude and square registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= mag;
    end
    if (ctl.mul) begin
      sq_r <= SQ_W'(mag_r) * SQ_W'(mag_r);
    end
  end

  // Block state: sum, count, first crossing
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      seen_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (ctl.load && !seen_r && over) begin
        seen_r <= 1'b1;
        idx_r  <= in_data.position;
      end
      // samples past the cap are only checked for crossing
      if (ctl.acc && (cnt_r < CAP)) begin
        sum_r <= sum_r + SUM_W'(sq_r);
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign sum   = sum_r;
  assign count = cnt_r;
  assign seen  = seen_r;
  assign index = idx_r;

  `ASSERT_CLK(a_cnt_cap, cnt_r <= CAP, "sample count passed the cap")
  `ASSERT_IMP(a_idx_clean, !seen_r, idx_r == '0, "crossing index set without a crossing")

endmodule

### rtl/core/rpf_csu.sv
// Shared compare/subtract unit used by both the divider and the square root.
// Depends on rpf_pkg.
`timescale 1ns / 1ps

module rpf_csu (
  input  logic [rpf_pkg::CSU_W-1:0] a,
  input  logic [rpf_pkg::CSU_W-1:0] b,
  output logic [rpf_pkg::CSU_W-1:0] diff,
  output logic                      ge
);
  import rpf_pkg::*;

  // One subtractor; the borrow gives the compare
  logic [CSU_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[CSU_W-1:0];
  assign ge   = !full[CSU_W];

endmodule

### rtl/core/rpf_dsq.sv
// Divide-then-root sequencer: restoring division of the sum by the count,
// then digit-by-digit integer square root, both on one rpf_csu.
// Depends on rpf_pkg, rpf_csu and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpf_dsq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpf_pkg::SUM_W-1:0]  dividend,
  input  logic [rpf_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [rpf_pkg::ROOT_W-1:0] root
);
  import rpf_pkg::*;

  localparam int ITW = $clog2(SUM_W);
  localparam logic [ITW-1:0] DIV_LAST  = ITW'(SUM_W - 1);
  localparam logic [ITW-1:0] SQRT_LAST = ITW'(SUM_W / 2 - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]        phase_r;
  logic [ITW-1:0]    it_r;
  logic              done_r;
  logic [SUM_W-1:0]  q_r;     // dividend -> quotient -> radicand shifter
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  dr_r;    // division remainder
  logic [SREM_W-1:0] srem_r;  // root remainder
  logic [ROOT_W-1:0] root_r;

  logic [CNT_W:0]    div_shift;
  logic [CSU_W-1:0]  sq_shift;
  logic [CSU_W-1:0]  op_a;
  logic [CSU_W-1:0]  op_b;
  logic [CSU_W-1:0]  diff;
  logic              ge;

  // Operand select for the shared unit
  always_comb begin
    div_shift = {dr_r, q_r[SUM_W-1]};
    sq_shift  = {srem_r, q_r[SUM_W-1 -: 2]};
    if (phase_r == PH_SQRT) begin
      op_a = sq_shift;
      op_b = CSU_W'({root_r, 2'b01});
    end else begin
      op_a = CSU_W'(div_shift);
      op_b = CSU_W'(den_r);
    end
  end

  rpf_csu u_csu (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      it_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_DIV;
            it_r    <= '0;
          end
        end
        PH_DIV: begin
          it_r <= it_r + ITW'(1);
          if (it_r == DIV_LAST) begin
            phase_r <= PH_SQRT;
            it_r    <= '0;
          end
        end
        PH_SQRT: begin
          it_r <= it_r + ITW'(1);
          if (it_r == SQRT_LAST) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // Datapath: one quotient bit or one root bit per cycle
  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE) begin
      if (start) begin
        q_r    <= dividend;
        den_r  <= divisor;
        dr_r   <= '0;
        srem_r <= '0;
        root_r <= '0;
      end
    end else if (phase_r == PH_DIV) begin
      dr_r <= ge ? diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
      q_r  <= {q_r[SUM_W-2:0], ge};
    end else begin
      srem_r <= ge ? diff[SREM_W-1:0] : sq_shift[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      q_r    <= {q_r[SUM_W-3:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

  `ASSERT_IMP(a_start_idle, start, phase_r == PH_IDLE, "start while divide/root busy")

endmodule

### rtl/core/block_rms_and_peak_finder.sv
// Top level of the block RMS and peak finder: sequencer, threshold register,
// output register. Depends on rpf_pkg, rpf_acc, rpf_dsq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Feed one sample per transaction with its buffer position; mark the block's
// final sample with last. Each sample that is not last passes through capture,
// multiply and accumulate. The last sample takes the same steps, then a start
// step, restoring division of the 64-bit sum by the count and square root, both
// run one bit a cycle on a single shared compare/subtract unit, then a done and
// an unload step. One result follows each last sample: rms_level =
// floor(sqrt(sum / count)) saturated to 0x7FFFFF, the first threshold crossing
// (magnitude strictly above peak_threshold) and the sample count; the block state
// then clears. Samples beyond MAX_FRAMES*MAX_CHANNELS in a block are checked for
// crossing only. The result sits in an output register, so the next samples are
// taken while it waits; a later last sample that finds that register still full
// holds in the unload step until it drains. Write peak_threshold only while the
// block is idle.
module block_rms_and_peak_finder #(
  parameter int MAX_FRAMES   = 16384,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rpf_pkg::rpf_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rpf_pkg::rpf_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [rpf_pkg::THR_W-1:0] cfg_wdata
);
  import rpf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic              last_r;
  logic [THR_W-1:0]  thr_r;
  logic              out_valid_r;
  rpf_out_t          out_data_r;

  rpf_acc_ctl_t      ctl;
  logic              accept;
  logic              unload;
  logic              dsq_start;
  logic              dsq_done;
  logic [ROOT_W-1:0] root;
  logic [THR_W-1:0]  rms_sat;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic              seen;
  logic [POS_W-1:0]  index;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign unload   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    dsq_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctl.load = accept;
        if (accept) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        ctl.acc   = 1'b1;
        state_nxt = last_r ? S_DIVGO : S_IDLE;
      end
      S_DIVGO: begin
        dsq_start = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (dsq_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ctl.clear = unload;
        if (unload) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_data.last;
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  rpf_acc #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .threshold (thr_r),
    .sum       (sum),
    .count     (count),
    .seen      (seen),
    .index     (index)
  );

  rpf_dsq u_dsq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dsq_start),
    .dividend (sum),
    .divisor  (count),
    .done     (dsq_done),
    .root     (root)
  );

  // Saturate full-scale root; empty block reads zero
  always_comb begin
    if (count == '0) begin
      rms_sat = '0;
    end else if (root > ROOT_W'(RMS_MAX)) begin
      rms_sat = RMS_MAX;
    end else begin
      rms_sat = root[THR_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (unload) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unload) begin
      out_data_r.rms_level     <= rms_sat;
      out_data_r.peak_found    <= seen;
      out_data_r.peak_position <= seen ? index : '0;
      out_data_r.sample_count  <= count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMP(a_done_in_root, dsq_done, state_r == S_ROOT, "root result outside wait state")
  `ASSERT_NXT(a_hold_done, (state_r == S_DONE) && out_valid_r && !out_ready,
              state_r == S_DONE, "result dropped while output register full")

endmodule
